// ----- hdl/dtpr_pkg.sv -----
// dtpr_pkg: shared widths, latency and register codes for the disparity reprojection block
// no dependencies; used by the top level, the divider pipeline and the port checker
`default_nettype none

package dtpr_pkg;

    localparam int COORD_W   = 12;   // row and column field width
    localparam int DISP_W    = 8;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int REG_W     = 32;   // config registers and coordinate results
    localparam int CFG_IDX_W = 3;

    // divisor w = divisor_offset - disparity * baseline_gain, exact
    localparam int W_W       = REG_W + DISP_W + 1;
    // quotient magnitude bits resolved by the divider, one above the result width
    localparam int QUO_W     = REG_W + 1;
    // divider: range check stage, one stage per quotient bit, sign and saturate stage
    localparam int DIV_LAT   = QUO_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X       = 3'd0,
        CFG_OFFSET_Y       = 3'd1,
        CFG_FOCAL_TERM     = 3'd2,
        CFG_BASELINE_GAIN  = 3'd3,
        CFG_DIVISOR_OFFSET = 3'd4
    } t_cfg_reg;

endpackage

`default_nettype wire

// ----- hdl/disparity_to_point_reprojection.sv -----
// disparity_to_point_reprojection: top level, config registers, front stages, output skid
// depends on dtpr_pkg and dtpr_divider; one pixel per cycle while o_in_ready is high
// four front stages (capture, scale and multiply, divisor, magnitudes) then a 35-stage divider per axis
// o_in_ready drops only while both output registers hold results
// reset (sync, active low) clears valid bits and sets config registers to their reset values
`default_nettype none

module disparity_to_point_reprojection #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // pixel input
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [dtpr_pkg::COORD_W-1:0]      i_row,
    input  wire logic [dtpr_pkg::COORD_W-1:0]      i_col,
    input  wire logic [dtpr_pkg::DISP_W-1:0]       i_disparity,
    input  wire logic [dtpr_pkg::CHAN_W-1:0]       i_blue,
    input  wire logic [dtpr_pkg::CHAN_W-1:0]       i_green,
    input  wire logic [dtpr_pkg::CHAN_W-1:0]       i_red,
    // point output
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [dtpr_pkg::REG_W-1:0]      o_point_x,
    output logic signed [dtpr_pkg::REG_W-1:0]      o_point_y,
    output logic signed [dtpr_pkg::REG_W-1:0]      o_point_z,
    output logic [dtpr_pkg::COLOR_W-1:0]           o_color,
    output logic                                   o_zero_divisor,
    // config write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dtpr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dtpr_pkg::REG_W-1:0]        i_cfg_data
);
    import dtpr_pkg::*;

    localparam int CB  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int CFW = CB + FRAC_BITS + 1;
    localparam int NB  = ((CFW > REG_W) ? CFW : REG_W) + 1;   // numerator width, signed
    localparam logic [REG_W-1:0] DIV_OFF_RST = REG_W'(64'd1 << FRAC_BITS);

    // config registers
    logic signed [REG_W-1:0] r_offset_x;
    logic signed [REG_W-1:0] r_offset_y;
    logic signed [REG_W-1:0] r_focal_term;
    logic signed [REG_W-1:0] r_baseline_gain;
    logic signed [REG_W-1:0] r_divisor_offset;

    logic en;

    // stage 1: captured pixel
    logic              r1_valid;
    logic [CB-1:0]     r1_row;
    logic [CB-1:0]     r1_col;
    logic [DISP_W-1:0] r1_disp;
    logic [COLOR_W-1:0] r1_color;

    // stage 2: numerators and disparity product
    logic                  r2_valid;
    logic signed [W_W-1:0] r2_prod;
    logic signed [NB-1:0]  r2_nx;
    logic signed [NB-1:0]  r2_ny;
    logic signed [NB-1:0]  r2_nz;
    logic [COLOR_W-1:0]    r2_color;
    logic signed [W_W-1:0] n2_prod;
    logic signed [NB-1:0]  n2_nx;
    logic signed [NB-1:0]  n2_ny;
    logic signed [NB-1:0]  n2_nz;

    // stage 3: divisor
    logic                  r3_valid;
    logic signed [W_W-1:0] r3_w;
    logic signed [NB-1:0]  r3_nx;
    logic signed [NB-1:0]  r3_ny;
    logic signed [NB-1:0]  r3_nz;
    logic [COLOR_W-1:0]    r3_color;
    logic signed [W_W-1:0] n3_w;

    // stage 4: magnitudes and signs
    logic               r4_valid;
    logic               r4_wzero;
    logic [W_W-1:0]     r4_wmag;
    logic [NB-1:0]      r4_xmag;
    logic [NB-1:0]      r4_ymag;
    logic [NB-1:0]      r4_zmag;
    logic               r4_xneg;
    logic               r4_yneg;
    logic               r4_zneg;
    logic [COLOR_W-1:0] r4_color;

    // sideband that rides alongside the dividers
    logic               r_sb_valid [0:DIV_LAT-1];
    logic               r_sb_zero  [0:DIV_LAT-1];
    logic [COLOR_W-1:0] r_sb_color [0:DIV_LAT-1];

    logic signed [REG_W-1:0] div_x;
    logic signed [REG_W-1:0] div_y;
    logic signed [REG_W-1:0] div_z;

    // final point before the output registers
    logic                    push;
    logic signed [REG_W-1:0] n_px;
    logic signed [REG_W-1:0] n_py;
    logic signed [REG_W-1:0] n_pz;

    // output register and skid register
    logic                    r_out_valid;
    logic                    r_skid_valid;
    logic signed [REG_W-1:0] r_skid_x;
    logic signed [REG_W-1:0] r_skid_y;
    logic signed [REG_W-1:0] r_skid_z;
    logic [COLOR_W-1:0]      r_skid_color;
    logic                    r_skid_zero;
    logic                    pop;

    assign en          = !r_skid_valid;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign pop         = r_out_valid && i_out_ready;
    assign push        = en && r_sb_valid[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x       <= '0;
            r_offset_y       <= '0;
            r_focal_term     <= '0;
            r_baseline_gain  <= '0;
            r_divisor_offset <= DIV_OFF_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET_X:       r_offset_x       <= i_cfg_data;
                CFG_OFFSET_Y:       r_offset_y       <= i_cfg_data;
                CFG_FOCAL_TERM:     r_focal_term     <= i_cfg_data;
                CFG_BASELINE_GAIN:  r_baseline_gain  <= i_cfg_data;
                CFG_DIVISOR_OFFSET: r_divisor_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n2_prod = $signed({1'b0, r1_disp}) * r_baseline_gain;
        n2_nx   = $signed(NB'(r1_col) << FRAC_BITS)
                  + $signed({{(NB-REG_W){r_offset_x[REG_W-1]}}, r_offset_x});
        n2_ny   = $signed(NB'(r1_row) << FRAC_BITS)
                  + $signed({{(NB-REG_W){r_offset_y[REG_W-1]}}, r_offset_y});
        n2_nz   = $signed({{(NB-REG_W){r_focal_term[REG_W-1]}}, r_focal_term});
        n3_w    = $signed({{(W_W-REG_W){r_divisor_offset[REG_W-1]}}, r_divisor_offset})
                  - r2_prod;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sb_valid[k] <= 1'b0;
            end
        end else if (en) begin
            // zero disparity enters as a bubble and gives no result
            r1_valid      <= i_in_valid && (i_disparity != '0);
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r_sb_valid[0] <= r4_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sb_valid[k] <= r_sb_valid[k-1];
            end
        end
    end

    // front stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_row   <= i_row[CB-1:0];
            r1_col   <= i_col[CB-1:0];
            r1_disp  <= i_disparity;
            r1_color <= {i_red, i_green, i_blue};

            r2_prod  <= n2_prod;
            r2_nx    <= n2_nx;
            r2_ny    <= n2_ny;
            r2_nz    <= n2_nz;
            r2_color <= r1_color;

            r3_w     <= n3_w;
            r3_nx    <= r2_nx;
            r3_ny    <= r2_ny;
            r3_nz    <= r2_nz;
            r3_color <= r2_color;

            r4_wzero <= (r3_w == '0);
            r4_wmag  <= r3_w[W_W-1] ? W_W'(-r3_w) : W_W'(r3_w);
            r4_xmag  <= r3_nx[NB-1] ? NB'(-r3_nx) : NB'(r3_nx);
            r4_ymag  <= r3_ny[NB-1] ? NB'(-r3_ny) : NB'(r3_ny);
            r4_zmag  <= r3_nz[NB-1] ? NB'(-r3_nz) : NB'(r3_nz);
            r4_xneg  <= r3_nx[NB-1] ^ r3_w[W_W-1];
            r4_yneg  <= r3_ny[NB-1] ^ r3_w[W_W-1];
            r4_zneg  <= r3_nz[NB-1] ^ r3_w[W_W-1];
            r4_color <= r3_color;

            r_sb_zero[0]  <= r4_wzero;
            r_sb_color[0] <= r4_color;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sb_zero[k]  <= r_sb_zero[k-1];
                r_sb_color[k] <= r_sb_color[k-1];
            end
        end
    end

    dtpr_divider #(
        .NUM_W     (NB),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_num_mag (r4_xmag),
        .i_den_mag (r4_wmag),
        .i_neg     (r4_xneg),
        .o_quot    (div_x)
    );

    dtpr_divider #(
        .NUM_W     (NB),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_num_mag (r4_ymag),
        .i_den_mag (r4_wmag),
        .i_neg     (r4_yneg),
        .o_quot    (div_y)
    );

    dtpr_divider #(
        .NUM_W     (NB),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_z (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_num_mag (r4_zmag),
        .i_den_mag (r4_wmag),
        .i_neg     (r4_zneg),
        .o_quot    (div_z)
    );

    // zero divisor forces the coordinates to zero
    always_comb begin
        n_px = r_sb_zero[DIV_LAT-1] ? '0 : div_x;
        n_py = r_sb_zero[DIV_LAT-1] ? '0 : div_y;
        n_pz = r_sb_zero[DIV_LAT-1] ? '0 : div_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= push;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                o_point_x      <= r_skid_x;
                o_point_y      <= r_skid_y;
                o_point_z      <= r_skid_z;
                o_color        <= r_skid_color;
                o_zero_divisor <= r_skid_zero;
            end
        end else if (!r_out_valid || pop) begin
            o_point_x      <= n_px;
            o_point_y      <= n_py;
            o_point_z      <= n_pz;
            o_color        <= r_sb_color[DIV_LAT-1];
            o_zero_divisor <= r_sb_zero[DIV_LAT-1];
        end else begin
            r_skid_x     <= n_px;
            r_skid_y     <= n_py;
            r_skid_z     <= n_pz;
            r_skid_color <= r_sb_color[DIV_LAT-1];
            r_skid_zero  <= r_sb_zero[DIV_LAT-1];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dtpr_divider.sv -----
// dtpr_divider: pipelined restoring divider, one quotient bit per stage, signed saturated result
// depends on dtpr_pkg; the pipeline advances only while i_en is high
`default_nettype none

module dtpr_divider #(
    parameter int NUM_W     = 34,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [NUM_W-1:0]                i_num_mag,
    input  wire logic [dtpr_pkg::W_W-1:0]        i_den_mag,
    input  wire logic                            i_neg,
    output logic signed [dtpr_pkg::REG_W-1:0]    o_quot
);
    import dtpr_pkg::*;

    localparam int MW = NUM_W + FRAC_BITS;            // scaled dividend width
    localparam int HW = MW - QUO_W;                   // bits above the resolved quotient
    localparam int CW = ((HW > W_W) ? HW : W_W) + 1;  // compare width of the range check

    localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'({1'b0, {(REG_W-1){1'b1}}});
    localparam logic [QUO_W-1:0] Q_NEG_MAX = QUO_W'({1'b1, {(REG_W-1){1'b0}}});
    localparam logic [REG_W-1:0] R_POS_SAT = {1'b0, {(REG_W-1){1'b1}}};
    localparam logic [REG_W-1:0] R_NEG_SAT = {1'b1, {(REG_W-1){1'b0}}};

    logic [MW-1:0]    n_dividend;
    logic [CW-1:0]    n_hi_ext;
    logic [CW-1:0]    n_den_ext;

    logic [W_W-1:0]   r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_lo  [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic [W_W-1:0]   r_den [0:QUO_W];
    logic             r_neg [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    logic [W_W:0]     n_trial [1:QUO_W];
    logic             n_ge    [1:QUO_W];
    logic [W_W:0]     n_diff  [1:QUO_W];

    logic [QUO_W-1:0] n_qneg;
    logic [REG_W-1:0] n_quot;

    // range check: quotient must stay below 2^QUO_W, else it saturates anyway
    always_comb begin
        n_dividend = {i_num_mag, {FRAC_BITS{1'b0}}};
        n_hi_ext   = {{(CW-HW){1'b0}}, n_dividend[MW-1:QUO_W]};
        n_den_ext  = {{(CW-W_W){1'b0}}, i_den_mag};
    end

    always_comb begin
        for (int k = 1; k <= QUO_W; k++) begin
            n_trial[k] = {r_rem[k-1], r_lo[k-1][QUO_W-1]};
            n_ge[k]    = (n_trial[k] >= {1'b0, r_den[k-1]});
            n_diff[k]  = n_trial[k] - {1'b0, r_den[k-1]};
        end
    end

    always_comb begin
        n_qneg = -r_q[QUO_W];
        if (r_neg[QUO_W]) begin
            if (r_ovf[QUO_W] || (r_q[QUO_W] > Q_NEG_MAX)) begin
                n_quot = R_NEG_SAT;
            end else begin
                n_quot = n_qneg[REG_W-1:0];
            end
        end else begin
            if (r_ovf[QUO_W] || (r_q[QUO_W] > Q_POS_MAX)) begin
                n_quot = R_POS_SAT;
            end else begin
                n_quot = r_q[QUO_W][REG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi_ext[W_W-1:0];
            r_lo[0]  <= n_dividend[QUO_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den_mag;
            r_neg[0] <= i_neg;
            r_ovf[0] <= (n_hi_ext >= n_den_ext);
            for (int k = 1; k <= QUO_W; k++) begin
                // remainder stays below the divisor, so the top bit drops out
                r_rem[k] <= n_ge[k] ? n_diff[k][W_W-1:0] : n_trial[k][W_W-1:0];
                r_lo[k]  <= {r_lo[k-1][QUO_W-2:0], 1'b0};
                r_q[k]   <= {r_q[k-1][QUO_W-2:0], n_ge[k]};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
            o_quot <= $signed(n_quot);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dtpr_checker.sv -----
// dtpr_checker: port-level assertions for the disparity reprojection top level
// depends on dtpr_pkg; attached to the top level by the bind at the end of this file
`default_nettype none

module dtpr_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_ready,
    input  wire logic [dtpr_pkg::COORD_W-1:0]      i_row,
    input  wire logic [dtpr_pkg::COORD_W-1:0]      i_col,
    input  wire logic [dtpr_pkg::DISP_W-1:0]       i_disparity,
    input  wire logic [dtpr_pkg::CHAN_W-1:0]       i_blue,
    input  wire logic [dtpr_pkg::CHAN_W-1:0]       i_green,
    input  wire logic [dtpr_pkg::CHAN_W-1:0]       i_red,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic [dtpr_pkg::REG_W-1:0]        o_point_x,
    input  wire logic [dtpr_pkg::REG_W-1:0]        o_point_y,
    input  wire logic [dtpr_pkg::REG_W-1:0]        o_point_z,
    input  wire logic [dtpr_pkg::COLOR_W-1:0]      o_color,
    input  wire logic                              o_zero_divisor,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              o_cfg_ready,
    input  wire logic [dtpr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dtpr_pkg::REG_W-1:0]        i_cfg_data
);
    import dtpr_pkg::*;

    // a zero divisor always comes with a point at the origin
    a_zero_div_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_divisor |->
            (o_point_x == '0) && (o_point_y == '0) && (o_point_z == '0))
        else $error("zero divisor transaction with nonzero coordinates");

    // input stalls only while a result is waiting at the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // a delivered result frees room for the next input
    a_pop_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> o_in_ready)
        else $error("input not ready after output transaction");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_z)
            && $stable(o_color) && $stable(o_zero_divisor))
        else $error("stalled output transaction changed");

endmodule

bind disparity_to_point_reprojection dtpr_checker u_dtpr_checker (.*);

`default_nettype wire
